// File: sv/mpsc_pkg.sv
// Shared types and operation codes for the MPSC ring claim/publish engine.
package mpsc_pkg;

  // Operation codes carried in the kind field of an input item.
  localparam logic [2:0] KIND_CLAIM   = 3'd0;
  localparam logic [2:0] KIND_PUBLISH = 3'd1;
  localparam logic [2:0] KIND_WAIT    = 3'd2;
  localparam logic [2:0] KIND_CONSUME = 3'd3;
  localparam logic [2:0] KIND_WRITE   = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [31:0] position;
    logic [15:0] length;
    logic [7:0]  byte_in;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] block_start;
    logic [15:0] block_len;
    logic [7:0]  byte_out;
    logic        stash_overflow;
  } out_item_t;

endpackage

// File: sv/mpsc_ram.sv
// Generic single-port RAM with registered read data.
module mpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write or one read per cycle; read data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: sv/mpsc_ring_claim_publish_engine_unit.sv
// Top level of the MPSC byte ring with claim, publish and consume pointers.
//
// Items enter on the in channel (in_valid_i / in_stall_o) and one result per
// item leaves on the out channel (out_valid_o / out_stall_i). The block works
// on one item at a time and stalls the input until that item is finished.
// Every ring address is the free-running pointer modulo RING_BYTES, found by
// a reciprocal multiplication on one shared 32x17 multiplier. Consume,
// unused kinds, a refused claim and an in-order publish need no remainder.
// A stash pass computes the publish address, checks the slots one at a time
// and computes the address anew for every parked block it applies; publish
// and wait repeat passes while they make progress. The next item is accepted
// in the cycle after the result is registered. The result sits in an output
// register; a stalled receiver holds it, and a new item may be accepted
// meanwhile, but its result waits until the held one has been taken. Reset
// clears the pointers, the stash and the output valid. The ring memory is
// not cleared: bytes read before they were written are undefined.
module mpsc_ring_claim_publish_engine_unit #(
  parameter int RING_BYTES  = 4096,
  parameter int STASH_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpsc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpsc_pkg::out_item_t out_item_o
);

  import mpsc_pkg::*;

  localparam int AW = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
  localparam int SW = (STASH_SLOTS > 1) ? $clog2(STASH_SLOTS) : 1;
  localparam int CW = $clog2(STASH_SLOTS + 1);
  localparam logic [16:0]   RingL   = 17'(RING_BYTES);
  localparam logic [AW-1:0] LastA   = AW'(RING_BYTES - 1);
  localparam logic [CW-1:0] SlotsC  = CW'(STASH_SLOTS);
  // Reciprocal of the ring size, scaled by 2^(32+AW).
  localparam logic [32:0]   RecipM  = 33'((65'd1 << (32 + AW)) / 65'(RING_BYTES));

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_MOD, S_CLAIM_W0, S_CLAIM_W1, S_PUB_TEST, S_PASS_CHK,
    S_PARK, S_WAIT_TEST, S_WAIT_DIFF, S_WAIT_RD0, S_WAIT_RD1, S_WAIT_RD2,
    S_RD0, S_RD1, S_WR, S_DONE
  } state_e;

  state_e state_q, state_d;
  state_e mod_ret_q, mod_ret_d;

  in_item_t  item_q, item_d;
  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [31:0] claim_ptr_q, claim_ptr_d;
  logic [31:0] publish_ptr_q, publish_ptr_d;
  logic [31:0] consume_ptr_q, consume_ptr_d;

  logic [STASH_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [AW-1:0]          slot_start_q [STASH_SLOTS];
  logic [AW-1:0]          slot_start_d [STASH_SLOTS];
  logic [15:0]            slot_len_q [STASH_SLOTS];
  logic [15:0]            slot_len_d [STASH_SLOTS];
  logic [CW-1:0]          slot_count_q, slot_count_d;
  logic [CW-1:0]          slot_idx_q, slot_idx_d;
  logic                   progress_q, progress_d;

  // Remainder unit state.
  logic [31:0]   mod_x_q, mod_x_d;
  logic [AW-1:0] mod_r_q, mod_r_d;
  logic [2:0]    mod_cnt_q, mod_cnt_d;
  logic [48:0]   mod_p_q, mod_p_d;
  logic [49:0]   mod_acc_q, mod_acc_d;
  logic [31:0]   mod_q_est;
  logic [31:0]   mul_a;
  logic [16:0]   mul_b;
  logic [48:0]   mul_p;
  logic [AW-1:0] addr_next;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [16:0] lo_len;
  logic [16:0] hi_len;
  logic [31:0] avail;
  logic [31:0] diff;
  logic [31:0] pub_next;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] cur_idx;

  // Rounds a claim size up to (n+3)&~1 and caps it at the ring size.
  function automatic logic [16:0] round_len(input logic [15:0] n);
    logic [16:0] r;
    r = {1'b0, n} + 17'd3;
    r[0] = 1'b0;
    if (r > RingL) begin
      r = RingL;
    end
    return r;
  endfunction

  mpsc_ram #(
    .WIDTH(8),
    .DEPTH(RING_BYTES)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Helper arithmetic shared by the sequencer.
  assign mod_q_est = 32'(mod_acc_q >> (16 + AW));
  assign addr_next = (mod_r_q == LastA) ? '0 : mod_r_q + AW'(1);
  assign lo_len    = round_len(item_q.min_len);
  assign hi_len    = round_len(item_q.max_len);
  assign avail     = consume_ptr_q - (claim_ptr_q - 32'(RING_BYTES));
  assign diff      = publish_ptr_q - consume_ptr_q;
  assign cur_idx   = slot_idx_q[SW-1:0];
  assign pub_next  = publish_ptr_q + {16'd0, slot_len_q[cur_idx]};

  // Operands of the shared multiplier for each remainder step.
  always_comb begin
    case (mod_cnt_q)
      3'd1: begin
        mul_a = mod_x_q;
        mul_b = RecipM[32:16];
      end
      3'd3: begin
        mul_a = mod_q_est;
        mul_b = RingL;
      end
      default: begin
        mul_a = mod_x_q;
        mul_b = {1'b0, RecipM[15:0]};
      end
    endcase
  end

  assign mul_p = 49'(mul_a) * 49'(mul_b);

  // First free stash slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < STASH_SLOTS; i++) begin
      if (!free_found && !slot_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d       = state_q;
    mod_ret_d     = mod_ret_q;
    item_d        = item_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    claim_ptr_d   = claim_ptr_q;
    publish_ptr_d = publish_ptr_q;
    consume_ptr_d = consume_ptr_q;
    slot_valid_d  = slot_valid_q;
    slot_start_d  = slot_start_q;
    slot_len_d    = slot_len_q;
    slot_count_d  = slot_count_q;
    slot_idx_d    = slot_idx_q;
    progress_d    = progress_q;
    mod_x_d       = mod_x_q;
    mod_r_d       = mod_r_q;
    mod_cnt_d     = mod_cnt_q;
    mod_p_d       = mod_p_q;
    mod_acc_d     = mod_acc_q;
    ram_we        = 1'b0;
    ram_addr      = mod_r_q;
    ram_wdata     = res_q.block_len[7:0];

    // The held result leaves when the receiver takes it.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          res_d   = '0;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (item_q.kind)
          KIND_CLAIM: begin
            if (!avail[31] && avail >= {15'd0, lo_len}) begin
              res_d.granted     = 1'b1;
              res_d.block_start = claim_ptr_q;
              res_d.block_len   = (avail >= {15'd0, hi_len}) ? hi_len[15:0] : avail[15:0];
              claim_ptr_d = claim_ptr_q +
                            ((avail >= {15'd0, hi_len}) ? {15'd0, hi_len} : avail);
              mod_x_d   = claim_ptr_q;
              mod_r_d   = '0;
              mod_cnt_d = '0;
              mod_ret_d = S_CLAIM_W0;
              state_d   = S_MOD;
            end else begin
              state_d = S_DONE;
            end
          end
          KIND_PUBLISH: state_d = S_PUB_TEST;
          KIND_WAIT:    state_d = S_WAIT_TEST;
          KIND_CONSUME: begin
            consume_ptr_d = consume_ptr_q + {16'd0, item_q.length};
            state_d       = S_DONE;
          end
          KIND_WRITE, KIND_READ: begin
            mod_x_d   = item_q.position;
            mod_r_d   = '0;
            mod_cnt_d = '0;
            mod_ret_d = (item_q.kind == KIND_WRITE) ? S_WR : S_RD0;
            state_d   = S_MOD;
          end
          default: state_d = S_DONE;
        endcase
      end

      // Remainder by reciprocal multiplication: estimate the quotient, take
      // the difference, then correct it by at most one ring size.
      S_MOD: begin
        mod_cnt_d = mod_cnt_q + 3'd1;
        case (mod_cnt_q)
          3'd0: mod_p_d = mul_p;
          3'd1: begin
            mod_acc_d = {18'd0, mod_p_q[47:16]};
            mod_p_d   = mul_p;
          end
          3'd2: mod_acc_d = mod_acc_q + {1'b0, mod_p_q};
          3'd3: mod_p_d = mul_p;
          3'd4: mod_acc_d = {18'd0, mod_x_q - mod_p_q[31:0]};
          default: begin
            mod_r_d = (mod_acc_q[16:0] >= RingL) ? AW'(mod_acc_q[16:0] - RingL)
                                                 : AW'(mod_acc_q[16:0]);
            state_d = mod_ret_q;
          end
        endcase
      end

      // Length header, low byte first, wrapping at the ring end.
      S_CLAIM_W0: begin
        ram_we    = 1'b1;
        ram_addr  = mod_r_q;
        ram_wdata = res_q.block_len[7:0];
        state_d   = S_CLAIM_W1;
      end

      S_CLAIM_W1: begin
        ram_we    = 1'b1;
        ram_addr  = addr_next;
        ram_wdata = res_q.block_len[15:8];
        state_d   = S_DONE;
      end

      // Publish in order if possible, else drain the stash, else park.
      S_PUB_TEST: begin
        if (publish_ptr_q == item_q.position) begin
          publish_ptr_d = item_q.position + {16'd0, item_q.length};
          state_d       = S_DONE;
        end else begin
          mod_r_d   = '0;
          mod_cnt_d = '0;
          mod_ret_d = (slot_count_q == '0) ? S_PARK : S_PASS_CHK;
          mod_x_d   = (slot_count_q == '0) ? item_q.position : publish_ptr_q;
          slot_idx_d = '0;
          progress_d = 1'b0;
          state_d    = S_MOD;
        end
      end

      // Stash pass: one slot per cycle against the publish address; a match stalls.
      S_PASS_CHK: begin
        if (slot_idx_q == SlotsC) begin
          if (item_q.kind == KIND_WAIT) begin
            state_d = progress_q ? S_WAIT_TEST : S_WAIT_DIFF;
          end else if (progress_q) begin
            state_d = S_PUB_TEST;
          end else begin
            mod_x_d   = item_q.position;
            mod_r_d   = '0;
            mod_cnt_d = '0;
            mod_ret_d = S_PARK;
            state_d   = S_MOD;
          end
        end else if (slot_valid_q[cur_idx] && slot_start_q[cur_idx] == mod_r_q) begin
          publish_ptr_d          = pub_next;
          slot_valid_d[cur_idx]  = 1'b0;
          slot_start_d[cur_idx]  = '0;
          slot_len_d[cur_idx]    = '0;
          slot_count_d           = slot_count_q - CW'(1);
          progress_d             = 1'b1;
          slot_idx_d             = slot_idx_q + CW'(1);
          mod_x_d   = pub_next;
          mod_r_d   = '0;
          mod_cnt_d = '0;
          mod_ret_d = S_PASS_CHK;
          state_d   = S_MOD;
        end else begin
          slot_idx_d = slot_idx_q + CW'(1);
        end
      end

      S_PARK: begin
        if (free_found) begin
          slot_valid_d[free_idx] = 1'b1;
          slot_start_d[free_idx] = mod_r_q;
          slot_len_d[free_idx]   = item_q.length;
          slot_count_d           = slot_count_q + CW'(1);
        end else begin
          res_d.stash_overflow = 1'b1;
        end
        state_d = S_DONE;
      end

      // Wait drains the stash until it is empty or a pass makes no progress.
      S_WAIT_TEST: begin
        if (slot_count_q != '0) begin
          mod_x_d    = publish_ptr_q;
          mod_r_d    = '0;
          mod_cnt_d  = '0;
          mod_ret_d  = S_PASS_CHK;
          slot_idx_d = '0;
          progress_d = 1'b0;
          state_d    = S_MOD;
        end else begin
          state_d = S_WAIT_DIFF;
        end
      end

      S_WAIT_DIFF: begin
        if (diff != 32'd0 && !diff[31]) begin
          res_d.granted     = 1'b1;
          res_d.block_start = consume_ptr_q;
          mod_x_d   = consume_ptr_q;
          mod_r_d   = '0;
          mod_cnt_d = '0;
          mod_ret_d = S_WAIT_RD0;
          state_d   = S_MOD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Header read: issue low byte, then high byte, capture each in the next cycle.
      S_WAIT_RD0: begin
        ram_addr = mod_r_q;
        state_d  = S_WAIT_RD1;
      end

      S_WAIT_RD1: begin
        ram_addr              = addr_next;
        res_d.block_len[7:0]  = ram_rdata;
        state_d               = S_WAIT_RD2;
      end

      S_WAIT_RD2: begin
        res_d.block_len[15:8] = ram_rdata;
        state_d               = S_DONE;
      end

      S_RD0: begin
        ram_addr = mod_r_q;
        state_d  = S_RD1;
      end

      S_RD1: begin
        res_d.byte_out = ram_rdata;
        state_d        = S_DONE;
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_addr  = mod_r_q;
        ram_wdata = item_q.byte_in;
        state_d   = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, pointers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mod_ret_q     <= S_IDLE;
      out_valid_q   <= 1'b0;
      claim_ptr_q   <= '0;
      publish_ptr_q <= '0;
      consume_ptr_q <= '0;
      slot_valid_q  <= '0;
      slot_count_q  <= '0;
      slot_idx_q    <= '0;
      progress_q    <= 1'b0;
      mod_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      mod_ret_q     <= mod_ret_d;
      out_valid_q   <= out_valid_d;
      claim_ptr_q   <= claim_ptr_d;
      publish_ptr_q <= publish_ptr_d;
      consume_ptr_q <= consume_ptr_d;
      slot_valid_q  <= slot_valid_d;
      slot_count_q  <= slot_count_d;
      slot_idx_q    <= slot_idx_d;
      progress_q    <= progress_d;
      mod_cnt_q     <= mod_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    res_q        <= res_d;
    out_q        <= out_d;
    mod_x_q      <= mod_x_d;
    mod_r_q      <= mod_r_d;
    mod_p_q      <= mod_p_d;
    mod_acc_q    <= mod_acc_d;
    slot_start_q <= slot_start_d;
    slot_len_q   <= slot_len_d;
  end

endmodule

// File: verif/tb_mpsc_ring_claim_publish_engine_unit.sv
// Self-checking testbench for the MPSC ring claim/publish engine.
`timescale 1ns / 1ps

module tb_mpsc_ring_claim_publish_engine_unit;
  import mpsc_pkg::*;

  localparam int RING = 4096;
  localparam int SLOTS = 8;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 600;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // Scoreboard: tracks the ring state and the queue of expected results.
  class ring_scoreboard;
    bit [31:0] claim_p, pub_p, cons_p;
    bit slot_v[SLOTS];
    bit [11:0] slot_s[SLOTS];
    bit [15:0] slot_l[SLOTS];
    int slot_n;
    bit [7:0] mem[RING];
    out_item_t expected_q[$];
    int errors;

    function bit [31:0] round_len(bit [31:0] n);
      n = (n + 32'd3) & ~32'd1;
      return (n > RING) ? RING : n;
    endfunction

    // One pass over the parked blocks; returns 1 if any was applied.
    function bit apply_parked();
      bit moved;
      moved = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_v[i] && slot_s[i] == pub_p[11:0]) begin
          pub_p += slot_l[i];
          slot_v[i] = 0;
          slot_s[i] = '0;
          slot_l[i] = '0;
          slot_n--;
          moved = 1;
        end
      end
      return moved;
    endfunction

    // Notes an accepted input item and returns the result it should give.
    function out_item_t note(in_item_t it);
      out_item_t r;
      bit [31:0] lo, hi, avail, diff;
      bit done;
      int i;
      r = '0;
      case (it.kind)
        KIND_CLAIM: begin
          lo = round_len(it.min_len);
          hi = round_len(it.max_len);
          avail = cons_p - (claim_p - RING);
          if (!avail[31] && avail >= lo) begin
            if (avail >= hi) avail = hi;
            r.block_start = claim_p;
            mem[claim_p % RING] = avail[7:0];
            mem[(claim_p + 1) % RING] = avail[15:8];
            claim_p += avail;
            r.granted = 1;
            r.block_len = avail[15:0];
          end
        end
        KIND_PUBLISH: begin
          done = 0;
          forever begin
            if (pub_p == it.position) begin
              pub_p = it.position + it.length;
              done = 1;
              break;
            end
            if (slot_n == 0 || !apply_parked()) break;
          end
          if (!done) begin
            for (i = 0; i < SLOTS; i++) begin
              if (!slot_v[i]) begin
                slot_v[i] = 1;
                slot_s[i] = it.position[11:0];
                slot_l[i] = it.length;
                slot_n++;
                break;
              end
            end
            if (i == SLOTS) r.stash_overflow = 1;
          end
        end
        KIND_WAIT: begin
          while (slot_n != 0 && apply_parked()) begin
          end
          diff = pub_p - cons_p;
          if (diff != 0 && !diff[31]) begin
            r.granted = 1;
            r.block_start = cons_p;
            r.block_len = {mem[(cons_p + 1) % RING], mem[cons_p % RING]};
          end
        end
        KIND_CONSUME: cons_p += it.length;
        KIND_WRITE: mem[it.position % RING] = it.byte_in;
        KIND_READ: r.byte_out = mem[it.position % RING];
        default: ;
      endcase
      expected_q.push_back(r);
      return r;
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.granted !== e.granted) begin
        $error("granted: expected %0h, got %0h", e.granted, got.granted);
        errors++;
      end
      if (got.block_start !== e.block_start) begin
        $error("block_start: expected %0h, got %0h", e.block_start, got.block_start);
        errors++;
      end
      if (got.block_len !== e.block_len) begin
        $error("block_len: expected %0h, got %0h", e.block_len, got.block_len);
        errors++;
      end
      if (got.byte_out !== e.byte_out) begin
        $error("byte_out: expected %0h, got %0h", e.byte_out, got.byte_out);
        errors++;
      end
      if (got.stash_overflow !== e.stash_overflow) begin
        $error("stash_overflow: expected %0h, got %0h", e.stash_overflow,
               got.stash_overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  out_item_t out_item_o;

  ring_scoreboard ring_sb = new();
  bit idle_on = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  // Claimed blocks not yet published, and lengths of claimed blocks not yet consumed.
  bit [31:0] open_start[$];
  bit [15:0] open_len[$];
  bit [15:0] len_at[bit [31:0]];
  // Positions written by byte writes, so reads only see written bytes.
  bit [31:0] wr_pos[$];

  mpsc_ring_claim_publish_engine_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Results are checked on the rising edge they are accepted at.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) ring_sb.check(out_item_o);
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        n = 0;
        while (n < 300) begin
          @(negedge clk_i);
          n++;
        end
        hold_req = 0;
        out_stall_i <= 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  // Builds an item with every field random, then sets the kind.
  function automatic in_item_t make_item(logic [2:0] kind);
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  // Offers one item until it is accepted; returns its expected result.
  task automatic send_item(in_item_t it, output out_item_t exp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    exp = ring_sb.note(it);
    @(negedge clk_i);
  endtask

  task automatic do_claim(logic [15:0] mn, logic [15:0] mx);
    in_item_t it;
    out_item_t exp;
    it = make_item(KIND_CLAIM);
    it.min_len = mn;
    it.max_len = mx;
    send_item(it, exp);
    if (exp.granted) begin
      open_start.push_back(exp.block_start);
      open_len.push_back(exp.block_len);
      len_at[exp.block_start] = exp.block_len;
    end
  endtask

  task automatic do_publish(int idx);
    in_item_t it;
    out_item_t exp;
    it = make_item(KIND_PUBLISH);
    it.position = open_start[idx];
    it.length = open_len[idx];
    open_start.delete(idx);
    open_len.delete(idx);
    send_item(it, exp);
  endtask

  task automatic do_simple(logic [2:0] kind, logic [31:0] pos, logic [15:0] len);
    in_item_t it;
    out_item_t exp;
    it = make_item(kind);
    it.position = pos;
    it.length = len;
    send_item(it, exp);
  endtask

  // Writes one random byte at a random position and notes the position.
  task automatic do_write();
    in_item_t it;
    out_item_t exp;
    it = make_item(KIND_WRITE);
    wr_pos.push_back(it.position);
    send_item(it, exp);
  endtask

  // Reads a byte at a written ring address, with random upper pointer bits.
  task automatic do_read();
    in_item_t it;
    out_item_t exp;
    logic [31:0] pos;
    logic [31:0] base;
    pos = $urandom;
    base = wr_pos[$urandom_range(0, wr_pos.size() - 1)];
    pos[11:0] = base[11:0];
    it = make_item(KIND_READ);
    it.position = pos;
    send_item(it, exp);
  endtask

  // Waits for a ready block and, when one is found, consumes it.
  task automatic do_wait_consume();
    in_item_t it;
    out_item_t exp;
    logic [15:0] len;
    it = make_item(KIND_WAIT);
    send_item(it, exp);
    if (exp.granted) begin
      len = len_at.exists(exp.block_start) ? len_at[exp.block_start] : exp.block_len;
      if (len_at.exists(exp.block_start)) len_at.delete(exp.block_start);
      do_simple(KIND_CONSUME, '0, len);
    end
  endtask

  initial begin
    in_item_t it;
    out_item_t exp;
    int r;

    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: smallest claim, refused claim, full-ring claim.
    do_claim(16'd0, 16'd0);
    do_claim(16'hFFFF, 16'hFFFF);
    do_publish(0);
    do_wait_consume();
    do_claim(16'hFFFF, 16'hFFFF);
    do_publish(0);
    do_wait_consume();
    do_wait_consume();

    // Directed: fill the stash with out-of-order publishes until it overflows.
    for (int k = 0; k < 10; k++) do_claim(16'd0, 16'd0);
    for (int k = 1; k < 10; k++) do_simple(KIND_PUBLISH, open_start[k], open_len[k]);
    do_simple(KIND_PUBLISH, open_start[0], open_len[0]);
    do_simple(KIND_PUBLISH, open_start[9], open_len[9]);
    open_start.delete();
    open_len.delete();
    for (int k = 0; k < 10; k++) do_wait_consume();

    // Directed: byte access at the top addresses, unused kinds, empty consume.
    it = make_item(KIND_WRITE);
    it.position = 32'hFFFF_FFFF;
    wr_pos.push_back(it.position);
    send_item(it, exp);
    do_simple(KIND_READ, 32'hFFFF_FFFF, '0);
    do_simple(KIND_READ, 32'(RING - 1), '0);
    do_simple(KIND_SPARE_A, '0, '0);
    do_simple(KIND_SPARE_B, '0, '0);
    do_simple(KIND_CONSUME, '0, '0);

    // Random part: mostly claim/publish/wait/consume flows, some noise.
    idle_on = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) hold_req = 1;
      if (n == 380) begin
        in_valid_i <= 0;
        while (ring_sb.expected_q.size() != 0) @(negedge clk_i);
      end
      if (n == RANDOM_ITEMS - 100) idle_on = 0;
      r = $urandom_range(0, 99);
      if (r < 25 && open_start.size() < 8) begin
        if ($urandom_range(0, 19) == 0) do_claim(16'($urandom_range(0, 60)), 16'hFFFF);
        else begin
          int mn;
          mn = $urandom_range(0, 120);
          do_claim(16'(mn), 16'(mn + $urandom_range(0, 400)));
        end
      end else if (r < 50 && open_start.size() != 0) begin
        do_publish($urandom_range(0, open_start.size() - 1));
      end else if (r < 70) begin
        do_wait_consume();
      end else if (r < 80) begin
        do_write();
      end else if (r < 90) begin
        do_read();
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(make_item($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B), exp);
          1: do_simple(KIND_CONSUME, $urandom, '0);
          2: send_item(make_item(KIND_WAIT), exp);
          default: do_claim(16'($urandom), 16'($urandom));
        endcase
      end
    end

    // Drain and deliver the verdict.
    in_valid_i <= 0;
    while (ring_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (ring_sb.errors == 0 && ring_sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mpsc_pkg.sv
sv/mpsc_ram.sv
sv/mpsc_ring_claim_publish_engine_unit.sv
verif/tb_mpsc_ring_claim_publish_engine_unit.sv
